// ----- hw/rtl/srpq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sorted request priority queue.
// No dependencies; used by the interfaces, the cell chain and the top level.
package srpq_pkg;

  // Queue depth and derived widths
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 8;
  localparam int PRI_W    = 8;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 3;
  localparam int PCNT_W   = 7;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_TAKE   = 2'd1,
    OP_COUNT  = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_PENDING = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NONE    = 3'd4;

  // One queue entry
  typedef struct packed {
    logic [ID_W-1:0]  snd;
    logic [ID_W-1:0]  rcv;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // Command broadcast to every cell
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_ROTATE = 2'd1,
    CMD_DROP   = 2'd2,
    CMD_INSERT = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] last_idx;
    entry_t           new_entry;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/srpq_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
// Depends on srpq_pkg for field widths.
interface srpq_req_if import srpq_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [ID_W-1:0]  user_id;
  logic [ID_W-1:0]  other_id;
  logic [PRI_W-1:0] priority_req;

  modport source (output valid, operation, user_id, other_id, priority_req, input ready);
  modport sink   (input valid, operation, user_id, other_id, priority_req, output ready);
endinterface

interface srpq_rsp_if import srpq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   sender_out;
  logic [PRI_W-1:0]  priority_out;
  logic [PCNT_W-1:0] pending_count;
  logic              last;

  modport source (output valid, status, sender_out, priority_out, pending_count, last,
                  input ready);
  modport sink   (input valid, status, sender_out, priority_out, pending_count, last,
                  output ready);
endinterface

// ----- hw/rtl/srpq_cell.sv -----
`timescale 1ns / 1ps
// One queue cell: holds an entry and moves it to/from its neighbors.
// Depends on srpq_pkg.
module srpq_cell import srpq_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  entry_t           head,
  input  entry_t           right,
  input  entry_t           left,
  input  logic             left_ge,
  output entry_t           entry,
  output logic             ge
);

  logic [CNT_W-1:0] idx_w;
  logic             valid;
  entry_t           entry_next;

  // Position and ordering flags
  assign idx_w = CNT_W'(idx);
  assign valid = idx_w < ctl.fill;
  assign ge    = valid && (entry.pri >= ctl.new_entry.pri);

  // Next entry per command
  always_comb begin
    entry_next = entry;
    case (ctl.cmd)
      CMD_ROTATE: begin
        if (idx_w == ctl.last_idx) entry_next = head;
        else if (valid) entry_next = right;
      end
      CMD_DROP: begin
        if (valid) entry_next = right;
      end
      CMD_INSERT: begin
        // cells at or after the slot shift up; the slot takes the new word
        if (idx_w <= ctl.fill && !ge) begin
          if (left_ge || idx_w == '0) entry_next = ctl.new_entry;
          else entry_next = left;
        end
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ----- hw/rtl/srpq_chain.sv -----
`timescale 1ns / 1ps
// Row of CAPACITY queue cells with neighbor links; cell 0 is the head.
// Depends on srpq_pkg and srpq_cell.
module srpq_chain import srpq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  output entry_t    head
);

  entry_t cell_entry [CAPACITY];
  logic   cell_ge    [CAPACITY];

  assign head = cell_entry[0];

  // Cells with links to their neighbors; the end cells tie the missing link to zero
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t right_n;
    entry_t left_n;
    logic   left_ge_n;

    if (g == CAPACITY - 1) begin : g_tail
      assign right_n = '0;
    end else begin : g_mid
      assign right_n = cell_entry[g+1];
    end

    if (g == 0) begin : g_first
      assign left_n    = '0;
      assign left_ge_n = 1'b0;
    end else begin : g_rest
      assign left_n    = cell_entry[g-1];
      assign left_ge_n = cell_ge[g-1];
    end

    srpq_cell u_cell (
      .clk     (clk),
      .idx     (IDX_W'(g)),
      .ctl     (ctl),
      .head    (cell_entry[0]),
      .right   (right_n),
      .left    (left_n),
      .left_ge (left_ge_n),
      .entry   (cell_entry[g]),
      .ge      (cell_ge[g])
    );
  end

endmodule

// ----- hw/rtl/sorted_request_priority_queue_core.sv -----
`timescale 1ns / 1ps
// Top level of the sorted request priority queue: sequencer, output register.
// Depends on srpq_pkg, srpq_if and srpq_chain.
//
//  port | dir  | words carried
//  req  | sink | operation, user_id, other_id, priority_req
//  rsp  | src  | status, sender_out, priority_out, pending_count, last
//
// For each item the cell row rotates once around its valid entries, one past the
// head each cycle; a successful insert then adds an insert step before done.
// A take drops its entry at the head during that same rotation.
// The rotation pauses whenever the response register is full and not taken.
// rst is synchronous; it empties the queue and the response register.
module sorted_request_priority_queue_core import srpq_pkg::*; (
  input  logic clk,
  input  logic rst,
  srpq_req_if.sink   req,
  srpq_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_INSERT = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] n0;
  logic [CNT_W-1:0] step;
  op_t              op;
  logic [ID_W-1:0]  uid;
  logic [ID_W-1:0]  oid;
  logic [PRI_W-1:0] pri;
  logic             pend, dup, full, found, held_valid;
  logic [CNT_W-1:0] cnt;
  entry_t           held;
  entry_t           taken;

  logic              out_valid;
  logic [STAT_W-1:0] out_st;
  logic [ID_W-1:0]   out_snd;
  logic [PRI_W-1:0]  out_pri;
  logic [PCNT_W-1:0] out_cnt;
  logic              out_last;

  entry_t            head;
  cell_ctl_t         ctl;
  logic              out_free, step_en, scan_end, drop, match_rcv, match_pair;
  logic              pend_next, dup_next, insert_ok, emit;
  logic [STAT_W-1:0] emit_st;
  logic [ID_W-1:0]   emit_snd;
  logic [PRI_W-1:0]  emit_pri;
  logic [PCNT_W-1:0] emit_cnt;
  logic              emit_last;

  srpq_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_st;
  assign rsp.sender_out    = out_snd;
  assign rsp.priority_out  = out_pri;
  assign rsp.pending_count = out_cnt;
  assign rsp.last          = out_last;

  // Head compare and step control
  always_comb begin
    out_free   = !out_valid || rsp.ready;
    step_en    = (state == S_SCAN) && out_free;
    scan_end   = step_en && (step == n0 - CNT_W'(1));
    match_rcv  = (head.rcv == uid);
    match_pair = (head.snd == uid) && (head.rcv == oid);
    drop       = step_en && (op == OP_TAKE) && match_rcv && !found;
    pend_next  = pend || ((op == OP_INSERT) && match_rcv);
    dup_next   = dup || ((op == OP_INSERT) && match_pair);
    insert_ok  = !pend_next && !dup_next && (fill != CNT_W'(CAPACITY));

    ctl.cmd       = CMD_HOLD;
    if (step_en) ctl.cmd = drop ? CMD_DROP : CMD_ROTATE;
    if (state == S_INSERT) ctl.cmd = CMD_INSERT;
    ctl.fill      = fill;
    ctl.last_idx  = fill - CNT_W'(1);
    ctl.new_entry = '{snd: uid, rcv: oid, pri: pri};
  end

  // Response word selection
  always_comb begin
    emit      = 1'b0;
    emit_st   = ST_OK;
    emit_snd  = '0;
    emit_pri  = '0;
    emit_cnt  = '0;
    emit_last = 1'b1;
    if (step_en && (op == OP_LIST) && match_rcv && held_valid) begin
      // a later match exists, so the held word is not the last
      emit      = 1'b1;
      emit_snd  = held.snd;
      emit_pri  = held.pri;
      emit_last = 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      emit = 1'b1;
      case (op)
        OP_INSERT: begin
          if (pend) emit_st = ST_PENDING;
          else if (dup) emit_st = ST_DUP;
          else if (full) emit_st = ST_FULL;
        end
        OP_TAKE: begin
          if (found) begin
            emit_snd = taken.snd;
            emit_pri = taken.pri;
          end else begin
            emit_st = ST_NONE;
          end
        end
        OP_COUNT: emit_cnt = PCNT_W'(cnt);
        OP_LIST: begin
          if (held_valid) begin
            emit_snd = held.snd;
            emit_pri = held.pri;
          end else begin
            emit_st = ST_NONE;
          end
        end
        default: emit_st = ST_NONE;
      endcase
    end
  end

  // Sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      if (emit) begin
        out_st   <= emit_st;
        out_snd  <= emit_snd;
        out_pri  <= emit_pri;
        out_cnt  <= emit_cnt;
        out_last <= emit_last;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op         <= op_t'(req.operation);
            uid        <= req.user_id;
            oid        <= req.other_id;
            pri        <= req.priority_req;
            n0         <= fill;
            step       <= '0;
            pend       <= 1'b0;
            dup        <= 1'b0;
            full       <= 1'b0;
            found      <= 1'b0;
            held_valid <= 1'b0;
            cnt        <= '0;
            if (fill != '0) state <= S_SCAN;
            else if (op_t'(req.operation) == OP_INSERT) state <= S_INSERT;
            else state <= S_DONE;
          end
        end
        S_SCAN: begin
          if (step_en) begin
            pend <= pend_next;
            dup  <= dup_next;
            step <= step + CNT_W'(1);
            if (drop) begin
              found <= 1'b1;
              taken <= head;
              fill  <= fill - CNT_W'(1);
            end
            if ((op == OP_COUNT) && match_rcv) cnt <= cnt + CNT_W'(1);
            if ((op == OP_LIST) && match_rcv) begin
              held       <= head;
              held_valid <= 1'b1;
            end
            if (scan_end) begin
              full  <= (fill == CNT_W'(CAPACITY));
              state <= ((op == OP_INSERT) && insert_ok) ? S_INSERT : S_DONE;
            end
          end
        end
        S_INSERT: begin
          fill  <= fill + CNT_W'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(CAPACITY))
    else $error("fill level above capacity");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (step < n0))
    else $error("scan step past start fill");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT) |=> (fill == $past(fill) + CNT_W'(1)))
    else $error("insert did not grow the queue by one");

  a_single_drop: assert property (@(posedge clk) disable iff (rst)
    (ctl.cmd == CMD_DROP) |-> (op == OP_TAKE && !found))
    else $error("more than one entry dropped");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && out_free) |=> (out_valid && out_last))
    else $error("final word missing last mark");

endmodule
